// ===== rtl/med_pkg.sv =====
// Shared types, constants and the Morse code table for the element decoder.
package med_pkg;

    localparam int MAX_SYMBOL_ELEMENTS = 6;
    localparam int DURATION_WIDTH      = 16;

    localparam int FIELD_W     = 16;
    localparam int DUR_CMP_W   = (DURATION_WIDTH < FIELD_W) ? DURATION_WIDTH : FIELD_W;
    localparam int LEN_W       = $clog2(MAX_SYMBOL_ELEMENTS + 2);
    localparam int PAT_W       = MAX_SYMBOL_ELEMENTS;
    localparam int CHAR_W      = 7;
    localparam int TABLE_SIZE  = 43;

    localparam logic [LEN_W-1:0] OVERFLOW_LEN = LEN_W'(MAX_SYMBOL_ELEMENTS + 1);
    localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(MAX_SYMBOL_ELEMENTS);

    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;

    localparam logic [1:0] REG_DASH_SPLIT   = 2'd0;
    localparam logic [1:0] REG_LETTER_PAUSE = 2'd1;
    localparam logic [1:0] REG_WORD_PAUSE   = 2'd2;
    localparam logic [1:0] REG_MIN_ON       = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] dash_split;
        logic [FIELD_W-1:0] letter_pause;
        logic [FIELD_W-1:0] word_pause;
        logic [FIELD_W-1:0] min_on;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] character;
        logic              has_space;
    } ev_t;

    typedef enum logic [1:0] {
        OB_EMPTY,
        OB_CHAR,
        OB_SPACE
    } ob_state_t;

    typedef struct packed {
        logic [7:0]        len;
        logic [7:0]        bits;
        logic [CHAR_W-1:0] ch;
    } code_entry_t;

    // dash = 1, first element in the highest used bit
    localparam code_entry_t CODE_TABLE [TABLE_SIZE] = '{
        '{8'd2, 8'd1,  7'h41}, '{8'd4, 8'd8,  7'h42}, '{8'd4, 8'd10, 7'h43},
        '{8'd3, 8'd4,  7'h44}, '{8'd1, 8'd0,  7'h45}, '{8'd4, 8'd2,  7'h46},
        '{8'd3, 8'd6,  7'h47}, '{8'd4, 8'd0,  7'h48}, '{8'd2, 8'd0,  7'h49},
        '{8'd4, 8'd7,  7'h4A}, '{8'd3, 8'd5,  7'h4B}, '{8'd4, 8'd4,  7'h4C},
        '{8'd2, 8'd3,  7'h4D}, '{8'd2, 8'd2,  7'h4E}, '{8'd3, 8'd7,  7'h4F},
        '{8'd4, 8'd6,  7'h50}, '{8'd4, 8'd13, 7'h51}, '{8'd3, 8'd2,  7'h52},
        '{8'd3, 8'd0,  7'h53}, '{8'd1, 8'd1,  7'h54}, '{8'd3, 8'd1,  7'h55},
        '{8'd4, 8'd1,  7'h56}, '{8'd3, 8'd3,  7'h57}, '{8'd4, 8'd9,  7'h58},
        '{8'd4, 8'd11, 7'h59}, '{8'd4, 8'd12, 7'h5A},
        '{8'd5, 8'd15, 7'h31}, '{8'd5, 8'd7,  7'h32}, '{8'd5, 8'd3,  7'h33},
        '{8'd5, 8'd1,  7'h34}, '{8'd5, 8'd0,  7'h35}, '{8'd5, 8'd16, 7'h36},
        '{8'd5, 8'd24, 7'h37}, '{8'd5, 8'd28, 7'h38}, '{8'd5, 8'd30, 7'h39},
        '{8'd5, 8'd31, 7'h30},
        '{8'd6, 8'd21, 7'h2E}, '{8'd6, 8'd51, 7'h2C}, '{8'd6, 8'd12, 7'h3F},
        '{8'd6, 8'd30, 7'h27}, '{8'd5, 8'd18, 7'h2F}, '{8'd6, 8'd33, 7'h2D},
        '{8'd5, 8'd17, 7'h3D}
    };

    function automatic logic [CHAR_W-1:0] lookup_symbol(
        input logic [LEN_W-1:0] len,
        input logic [PAT_W-1:0] pat
    );
        logic [CHAR_W-1:0] ch;
        ch = CHAR_UNKNOWN;
        if (len != '0 && len <= MAX_LEN) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                if (CODE_TABLE[i].len == 8'(len) && CODE_TABLE[i].bits == 8'(pat)) begin
                    ch = CODE_TABLE[i].ch;
                end
            end
        end
        return ch;
    endfunction

endpackage

// ===== rtl/med_regs.sv =====
// Configuration register file: thresholds for dash, letter gap, word gap, noise.
module med_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [15:0]            cfg_wdata,
    output med_pkg::cfg_t          cfg
);
    import med_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DASH_SPLIT:   cfg_next.dash_split   = cfg_wdata;
                REG_LETTER_PAUSE: cfg_next.letter_pause = cfg_wdata;
                REG_WORD_PAUSE:   cfg_next.word_pause   = cfg_wdata;
                REG_MIN_ON:       cfg_next.min_on       = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dash_split   <= 16'd1200;
            cfg_reg.letter_pause <= 16'd1800;
            cfg_reg.word_pause   <= 16'd4200;
            cfg_reg.min_on       <= 16'd50;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/med_sym.sv =====
// Input register, element classification, symbol accumulation and lookup.
module med_sym (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  med_pkg::cfg_t          cfg,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [15:0] on_time, [31:16] gap_time
    input  logic                   s_tlast,   // final_element
    output med_pkg::ev_t           ev,
    input  logic                   ev_ready
);
    import med_pkg::*;

    logic               in_valid_reg;
    logic [FIELD_W-1:0] on_reg;
    logic [FIELD_W-1:0] gap_reg;
    logic               fin_reg;
    logic [PAT_W-1:0]   pat_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [PAT_W-1:0]   pat_next;
    logic [LEN_W-1:0]   len_next;
    logic [PAT_W-1:0]   pat_grown;
    logic [LEN_W-1:0]   len_grown;
    logic               noise;
    logic               dash;
    logic               word_end;
    logic               letter_end;
    logic               emit;
    logic               fire;

    always_comb begin
        noise      = on_reg[DUR_CMP_W-1:0] < cfg.min_on[DUR_CMP_W-1:0];
        dash       = on_reg[DUR_CMP_W-1:0] >= cfg.dash_split[DUR_CMP_W-1:0];
        word_end   = gap_reg[DUR_CMP_W-1:0] >= cfg.word_pause[DUR_CMP_W-1:0];
        letter_end = gap_reg[DUR_CMP_W-1:0] >= cfg.letter_pause[DUR_CMP_W-1:0];

        if (len_reg < MAX_LEN) begin
            pat_grown = {pat_reg[PAT_W-2:0], dash};
            len_grown = len_reg + LEN_W'(1);
        end else begin
            pat_grown = pat_reg;
            len_grown = OVERFLOW_LEN;
        end

        emit          = !noise && (fin_reg || word_end || letter_end);
        ev.valid      = in_valid_reg && emit;
        ev.character  = lookup_symbol(len_grown, pat_grown);
        ev.has_space  = !fin_reg && word_end;
        fire          = in_valid_reg && (ev_ready || !emit);

        pat_next = pat_reg;
        len_next = len_reg;
        if (fire) begin
            if (noise) begin
                if (fin_reg) begin
                    pat_next = '0;
                    len_next = '0;
                end
            end else if (emit) begin
                pat_next = '0;
                len_next = '0;
            end else begin
                pat_next = pat_grown;
                len_next = len_grown;
            end
        end
    end

    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pat_reg      <= '0;
            len_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            pat_reg <= pat_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            on_reg  <= s_tdata[15:0];
            gap_reg <= s_tdata[31:16];
            fin_reg <= s_tlast;
        end
    end

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= OVERFLOW_LEN)
        else $error("symbol length beyond overflow mark");

    a_empty_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg == '0 |-> pat_reg == '0)
        else $error("empty symbol holds pattern bits");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ev.valid && ev_ready |=> len_reg == '0)
        else $error("symbol not cleared after character emitted");

endmodule

// ===== rtl/med_out.sv =====
// Result buffer: holds one character and an optional trailing space.
module med_out (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  med_pkg::ev_t           ev,
    output logic                   ev_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [6:0] character, [7] zero
    output logic                   m_tlast    // last_of_run
);
    import med_pkg::*;

    ob_state_t         state_reg;
    ob_state_t         state_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              space_reg;
    logic              space_next;

    always_comb begin
        state_next = state_reg;
        char_next  = char_reg;
        space_next = space_reg;
        ev_ready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tdata    = {1'b0, char_reg};
        m_tlast    = 1'b1;
        case (state_reg)
            OB_EMPTY: begin
                ev_ready = 1'b1;
            end
            OB_CHAR: begin
                m_tvalid = 1'b1;
                m_tlast  = !space_reg;
                if (m_tready) begin
                    if (space_reg) begin
                        state_next = OB_SPACE;
                    end else begin
                        state_next = OB_EMPTY;
                        ev_ready   = 1'b1;
                    end
                end
            end
            OB_SPACE: begin
                m_tvalid = 1'b1;
                m_tdata  = {1'b0, CHAR_SPACE};
                if (m_tready) begin
                    state_next = OB_EMPTY;
                    ev_ready   = 1'b1;
                end
            end
            default: begin
                state_next = OB_EMPTY;
            end
        endcase
        if (ev_ready && ev.valid) begin
            state_next = OB_CHAR;
            char_next  = ev.character;
            space_next = ev.has_space;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OB_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg  <= char_next;
        space_reg <= space_next;
    end

    a_space_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == OB_CHAR && space_reg && m_tready |=> state_reg == OB_SPACE)
        else $error("word break space lost");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ev.valid && ev_ready |=> state_reg == OB_CHAR && m_tdata[6:0] == $past(ev.character))
        else $error("loaded character not presented");

    a_space_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == OB_SPACE |-> m_tvalid && m_tlast && m_tdata[6:0] == CHAR_SPACE)
        else $error("space beat malformed");

endmodule

// ===== rtl/morse_element_decoder.sv =====
// Morse element decoder: keyed elements in, decoded ASCII characters out.
//
// Each input beat is one keyed element, held in the input register; its result is
// registered in the single result buffer, which drives the output. One element is
// taken every cycle while the output is drained; an element that ends a word yields two
// output beats (character, then space), both held in the buffer. Thresholds are written
// through the cfg port; the user must do so while no element is in flight (unchecked).
module morse_element_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] on_time, [31:16] gap_time
    input  logic        s_tlast,   // final_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
    output logic        m_tlast    // last_of_run
);
    import med_pkg::*;

    cfg_t cfg;
    ev_t  ev;
    logic ev_ready;

    med_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    med_sym u_sym (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .ev       (ev),
        .ev_ready (ev_ready)
    );

    med_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev       (ev),
        .ev_ready (ev_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for morse_element_decoder: random keyed elements against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import med_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [15:0] on_time;
        logic [15:0] gap_time;
        logic        last_el;
    } element_t;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last_of_run;
    } char_beat_t;

    typedef enum {TONE_NOISE, TONE_DOT, TONE_DASH} tone_kind_t;
    typedef enum {GAP_SHORT, GAP_LETTER, GAP_WORD} gap_kind_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    morse_element_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // decoder shadow: thresholds and symbol being built
    logic [15:0] dash_split_r   = 16'd1200;
    logic [15:0] letter_pause_r = 16'd1800;
    logic [15:0] word_pause_r   = 16'd4200;
    logic [15:0] min_on_r       = 16'd50;
    logic [5:0]  sym_pat        = '0;
    logic [2:0]  sym_len        = '0;

    element_t   pending_q[$];
    char_beat_t expected_chars[$];
    int unsigned queued_elements   = 0;
    int unsigned accepted_elements = 0;
    int unsigned errors            = 0;
    int unsigned quiet_cycles      = 0;
    int          send_idle_pct     = 36;
    int          recv_idle_pct     = 74;
    bit          rx_hold           = 1'b0;
    element_t    next_el;
    char_beat_t  want;

    function automatic logic [CHAR_W-1:0] morse_char(logic [2:0] len, logic [5:0] pat);
        case ({len, pat})
            {3'd1, 6'd0}:  return 7'h45;  {3'd1, 6'd1}:  return 7'h54;
            {3'd2, 6'd0}:  return 7'h49;  {3'd2, 6'd1}:  return 7'h41;
            {3'd2, 6'd2}:  return 7'h4E;  {3'd2, 6'd3}:  return 7'h4D;
            {3'd3, 6'd0}:  return 7'h53;  {3'd3, 6'd1}:  return 7'h55;
            {3'd3, 6'd2}:  return 7'h52;  {3'd3, 6'd3}:  return 7'h57;
            {3'd3, 6'd4}:  return 7'h44;  {3'd3, 6'd5}:  return 7'h4B;
            {3'd3, 6'd6}:  return 7'h47;  {3'd3, 6'd7}:  return 7'h4F;
            {3'd4, 6'd0}:  return 7'h48;  {3'd4, 6'd1}:  return 7'h56;
            {3'd4, 6'd2}:  return 7'h46;  {3'd4, 6'd4}:  return 7'h4C;
            {3'd4, 6'd6}:  return 7'h50;  {3'd4, 6'd7}:  return 7'h4A;
            {3'd4, 6'd8}:  return 7'h42;  {3'd4, 6'd9}:  return 7'h58;
            {3'd4, 6'd10}: return 7'h43;  {3'd4, 6'd11}: return 7'h59;
            {3'd4, 6'd12}: return 7'h5A;  {3'd4, 6'd13}: return 7'h51;
            {3'd5, 6'd0}:  return 7'h35;  {3'd5, 6'd1}:  return 7'h34;
            {3'd5, 6'd3}:  return 7'h33;  {3'd5, 6'd7}:  return 7'h32;
            {3'd5, 6'd15}: return 7'h31;  {3'd5, 6'd16}: return 7'h36;
            {3'd5, 6'd17}: return 7'h3D;  {3'd5, 6'd18}: return 7'h2F;
            {3'd5, 6'd24}: return 7'h37;  {3'd5, 6'd28}: return 7'h38;
            {3'd5, 6'd30}: return 7'h39;  {3'd5, 6'd31}: return 7'h30;
            {3'd6, 6'd12}: return 7'h3F;  {3'd6, 6'd21}: return 7'h2E;
            {3'd6, 6'd30}: return 7'h27;  {3'd6, 6'd33}: return 7'h2D;
            {3'd6, 6'd51}: return 7'h2C;
            default:       return CHAR_UNKNOWN;
        endcase
    endfunction

    function automatic void decode_element(element_t e);
        logic       dash;
        logic       word_end;
        char_beat_t b;
        if (e.on_time < min_on_r) begin
            // noise spike; on a final element it still ends the window
            if (e.last_el) begin
                sym_pat = '0;
                sym_len = '0;
            end
            return;
        end
        dash = (e.on_time >= dash_split_r);
        if (sym_len < MAX_LEN) begin
            sym_pat = {sym_pat[4:0], dash};
            sym_len = sym_len + 3'd1;
        end else begin
            sym_len = OVERFLOW_LEN;
        end
        word_end = !e.last_el && (e.gap_time >= word_pause_r);
        if (e.last_el || word_end || e.gap_time >= letter_pause_r) begin
            b.character   = morse_char(sym_len, sym_pat);
            b.last_of_run = !word_end;
            expected_chars = {expected_chars, b};
            if (word_end) begin
                b.character   = CHAR_SPACE;
                b.last_of_run = 1'b1;
                expected_chars = {expected_chars, b};
            end
            sym_pat = '0;
            sym_len = '0;
        end
    endfunction

    // element driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                next_el.on_time  = s_tdata[15:0];
                next_el.gap_time = s_tdata[31:16];
                next_el.last_el  = s_tlast;
                decode_element(next_el);
                accepted_elements++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_el = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_el.gap_time, next_el.on_time};
                    s_tlast  <= next_el.last_el;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // character monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat: expected none, actual char %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[6:0] !== want.character || m_tdata[7] !== 1'b0 ||
                        m_tlast !== want.last_of_run) begin
                        errors++;
                        $display("%0t: mismatch: expected char %h last %b, actual tdata %h last %b",
                                 $time, want.character, want.last_of_run, m_tdata, m_tlast);
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_element(input logic [15:0] on_t, input logic [15:0] gap_t,
                               input logic last_el);
        element_t e;
        e.on_time  = on_t;
        e.gap_time = gap_t;
        e.last_el  = last_el;
        pending_q = {pending_q, e};
        queued_elements++;
    endtask

    function automatic logic [15:0] in_range(int lo, int hi);
        if (lo > hi) return 16'($urandom);
        case ($urandom_range(9))
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic logic [15:0] tone_len(tone_kind_t kind);
        int mo;
        int ds;
        mo = int'(min_on_r);
        ds = int'(dash_split_r);
        case (kind)
            TONE_NOISE: return in_range(0, mo - 1);
            TONE_DOT:   return in_range(mo, ds - 1);
            default:    return in_range((mo > ds) ? mo : ds, 65535);
        endcase
    endfunction

    function automatic logic [15:0] gap_len(gap_kind_t kind);
        int lg;
        int wg;
        lg = int'(letter_pause_r);
        wg = int'(word_pause_r);
        case (kind)
            GAP_SHORT:  return in_range(0, ((lg < wg) ? lg : wg) - 1);
            GAP_LETTER: return in_range(lg, wg - 1);
            default:    return in_range(wg, 65535);
        endcase
    endfunction

    // one letter: dots and dashes with short gaps, closed by a letter gap,
    // a word gap or a final element; noise and raw beats mixed in
    task automatic add_symbol(inout int budget);
        int         n;
        int         r;
        tone_kind_t kind;
        if ($urandom_range(99) < 8) begin
            add_element(16'($urandom), 16'($urandom), 1'($urandom));
            budget--;
            return;
        end
        n = ($urandom_range(99) < 10) ? $urandom_range(8, 7) : $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 6)
                add_element(tone_len(TONE_NOISE), 16'($urandom), $urandom_range(99) < 5);
            kind = $urandom_range(1) ? TONE_DASH : TONE_DOT;
            if (i < n - 1) begin
                add_element(tone_len(kind), gap_len(GAP_SHORT), 1'b0);
            end else begin
                r = $urandom_range(99);
                if (r < 15)
                    add_element(tone_len(kind), 16'($urandom), 1'b1);
                else if (r < 60)
                    add_element(tone_len(kind), gap_len(GAP_LETTER), 1'b0);
                else
                    add_element(tone_len(kind), gap_len(GAP_WORD), 1'b0);
            end
            budget--;
        end
    endtask

    task automatic wait_drained();
        while (accepted_elements != queued_elements || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DASH_SPLIT:   dash_split_r   = val;
            REG_LETTER_PAUSE: letter_pause_r = val;
            REG_WORD_PAUSE:   word_pause_r   = val;
            REG_MIN_ON:       min_on_r       = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [15:0] ds, input logic [15:0] lg,
                             input logic [15:0] wg, input logic [15:0] mo,
                             input int count, input int sidle, input int ridle,
                             input bit hold);
        int budget;
        wait_drained();
        write_reg(REG_DASH_SPLIT, ds);
        write_reg(REG_LETTER_PAUSE, lg);
        write_reg(REG_WORD_PAUSE, wg);
        write_reg(REG_MIN_ON, mo);
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        send_idle_pct <= sidle;
        recv_idle_pct <= ridle;
        budget = count / 2;
        while (budget > 0) add_symbol(budget);
        if (hold) begin
            // output blocked while elements keep coming
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
        // sender stays quiet until the decoder is empty
        wait_drained();
        budget = count - count / 2;
        while (budget > 0) add_symbol(budget);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset thresholds: dash 1200, letter 1800, word 4200, min_on 50
        add_element(16'd0, 16'hFFFF, 1'b0);      // noise, gap ignored
        add_element(16'hFFFF, 16'hFFFF, 1'b0);   // T + space
        add_element(16'd100, 16'd300, 1'b0);
        add_element(16'd2000, 16'd1800, 1'b0);   // A
        add_element(16'd50, 16'd1799, 1'b0);
        add_element(16'd1199, 16'd0, 1'b0);
        add_element(16'd1200, 16'd4200, 1'b0);   // U + space
        add_element(16'd100, 16'd0, 1'b0);
        add_element(16'd49, 16'hFFFF, 1'b1);     // noise on final clears the dot
        add_element(16'd100, 16'd1800, 1'b0);    // E
        add_element(16'd2000, 16'hFFFF, 1'b1);   // final: T only
        add_element(16'd1199, 16'd4199, 1'b0);   // E
        repeat (6) add_element(16'd100, 16'd0, 1'b0);
        add_element(16'd100, 16'd1800, 1'b0);    // seven elements: unknown

        run_phase(16'd1200, 16'd1800, 16'd4200, 16'd50, 140, 36, 74, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 100, 36, 74, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 36, 74, 1'b0);
        run_phase(16'd20, 16'd30, 16'd60, 16'd5, 140, 74, 36, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  160, 74, 36, 1'b0);
        run_phase(16'd300, 16'd900, 16'd500, 16'd40, 140, 74, 36, 1'b0);
        run_phase(16'd100, 16'd400, 16'd1500, 16'd300, 160, 0, 0, 1'b1);
        run_phase(16'($urandom_range(3000)), 16'($urandom_range(3000)),
                  16'($urandom_range(3000)), 16'($urandom_range(3000)), 160, 0, 0, 1'b0);

        wait_drained();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/med_pkg.sv
rtl/med_regs.sv
rtl/med_sym.sv
rtl/med_out.sv
rtl/morse_element_decoder.sv
sim/testbench.sv
